// File: rtl/ppc_pkg.sv
// ----------------------------------------------------------------------------
// ppc_pkg: shared types and constants
// Controller states, controller-to-datapath commands and datapath status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ppc_pkg;

  // width of the saturating running counters
  localparam int unsigned CntW = 32;

  // divide by ten as (x * TenRecip) >> TenShift, exact for any 32-bit x
  localparam logic [31:0] TenRecip = 32'hCCCC_CCCD;
  localparam int unsigned TenShift = 35;

  // first trial divisor and its square
  localparam int unsigned FirstDiv = 2;
  localparam int unsigned FirstSq  = FirstDiv * FirstDiv;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_PAL_DIV,
    ST_PAL_STEP,
    ST_PAL_END,
    ST_PRM_CHK,
    ST_PRM_WAIT,
    ST_FINISH
  } ppc_state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load;       // capture a new request
    logic dig_div;    // register rest / 10
    logic div_start;  // launch the trial divider on n / d
    logic pal_step;   // fold one digit into the reversed value
    logic pal_set;    // latch palindrome flag
    logic prm_init;   // d = 2, d*d = 4
    logic prm_step;   // d = d + 1, square updated
    logic prm_set;    // no divisor found: prime
    logic finish;     // load result flags, bump counters
  } ppc_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic neg;        // captured number is negative
    logic div_done;   // divider result ready (one-cycle pulse)
    logic quo_zero;   // rest / 10 is zero
    logic rem_zero;   // trial remainder is zero
    logic le_one;     // number is 0 or 1
    logic sq_gt_n;    // d*d exceeds number
  } ppc_sts_t;

endpackage

`default_nettype wire

// File: rtl/ppc_div.sv
// ----------------------------------------------------------------------------
// ppc_div: radix-2 restoring divider
// Unsigned division of a non-negative value, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppc_div #(
  parameter int unsigned NUMBER_WIDTH = 32
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic [NUMBER_WIDTH-1:0] dividend_i,
  input  wire logic [NUMBER_WIDTH-1:0] divisor_i,
  output logic                         done_o,
  output logic [NUMBER_WIDTH-1:0]      rem_o
);

  localparam int unsigned CntW = $clog2(NUMBER_WIDTH + 1);

  logic [NUMBER_WIDTH-1:0] quo_q, quo_d;
  logic [NUMBER_WIDTH-1:0] rem_q, rem_d;
  logic [NUMBER_WIDTH-1:0] dvs_q, dvs_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic [NUMBER_WIDTH-1:0] shifted;
  logic                    ge;

  // remainder stays below the divisor, so its top bit is always clear
  assign shifted = {rem_q[NUMBER_WIDTH-2:0], quo_q[NUMBER_WIDTH-1]};
  assign ge      = (shifted >= dvs_q);

  // one restoring step per cycle
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CntW'(NUMBER_WIDTH);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[NUMBER_WIDTH-2:0], ge};
      rem_d = ge ? (shifted - dvs_q) : shifted;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// File: rtl/ppc_dpath.sv
// ----------------------------------------------------------------------------
// ppc_dpath: classifier datapath
// Number, digit reversal, trial divisor and its square, flags and counters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppc_dpath
  import ppc_pkg::*;
#(
  parameter int unsigned NUMBER_WIDTH = 32
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic [NUMBER_WIDTH-1:0] number_i,
  input  wire ppc_cmd_t                cmd_i,
  output ppc_sts_t                     sts_o,
  output logic                         is_prime_o,
  output logic                         is_palindrome_o,
  output logic                         is_palindromic_prime_o,
  output logic [CntW-1:0]              prime_count_o,
  output logic [CntW-1:0]              palindrome_count_o,
  output logic [CntW-1:0]              both_count_o,
  output logic [CntW-1:0]              total_count_o
);

  localparam int unsigned W    = NUMBER_WIDTH;
  localparam int unsigned RevW = NUMBER_WIDTH + 3;  // reversed value < 10 * number

  logic [W-1:0]    n_q;
  logic [W-1:0]    rest_q;
  logic [W-1:0]    dig_quo_q;
  logic [RevW-1:0] rev_q;
  logic [W-1:0]    d_q;
  logic [W:0]      sq_q;
  logic            prime_q, pal_q;
  logic            out_prime_q, out_pal_q, out_both_q;
  logic [CntW-1:0] prime_cnt_q, pal_cnt_q, both_cnt_q, total_cnt_q;

  logic [W-1:0]    div_rem;
  logic            div_done;
  logic [31:0]     rest_ext;
  logic [63:0]     ten_prod;
  logic [W-1:0]    dig_x10;
  logic [W-1:0]    dig_rem;
  logic [RevW-1:0] rev_next;

  // trial division of n by d
  ppc_div #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (n_q),
    .divisor_i  (d_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // rest / 10 by reciprocal multiplication, registered before use
  assign rest_ext = 32'(rest_q);
  assign ten_prod = 64'(rest_ext) * 64'(TenRecip);

  // digit = rest - 10 * (rest / 10)
  assign dig_x10 = {dig_quo_q[W-4:0], 3'b000} + {dig_quo_q[W-2:0], 1'b0};
  assign dig_rem = rest_q - dig_x10;

  // rev * 10 + digit, as shifts and adds
  assign rev_next = {rev_q[RevW-4:0], 3'b000} + {rev_q[RevW-2:0], 1'b0}
                  + {3'b000, dig_rem};

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q    <= number_i;
      rest_q <= number_i;
      rev_q  <= '0;
    end
    if (cmd_i.dig_div) begin
      dig_quo_q <= W'(ten_prod[63:TenShift]);
    end
    if (cmd_i.pal_step) begin
      rev_q  <= rev_next;
      rest_q <= dig_quo_q;
    end
    if (cmd_i.prm_init) begin
      d_q  <= W'(FirstDiv);
      sq_q <= (W + 1)'(FirstSq);
    end else if (cmd_i.prm_step) begin
      d_q  <= d_q + 1'b1;
      sq_q <= sq_q + {d_q, 1'b1};  // (d+1)^2 = d^2 + 2d + 1
    end
  end

  // per-item flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prime_q <= 1'b0;
      pal_q   <= 1'b0;
    end else if (cmd_i.load) begin
      prime_q <= 1'b0;
      pal_q   <= 1'b0;
    end else begin
      if (cmd_i.pal_set) pal_q <= (rev_q == {3'b000, n_q});
      if (cmd_i.prm_set) prime_q <= 1'b1;
    end
  end

  // result flags and saturating counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_prime_q <= 1'b0;
      out_pal_q   <= 1'b0;
      out_both_q  <= 1'b0;
      prime_cnt_q <= '0;
      pal_cnt_q   <= '0;
      both_cnt_q  <= '0;
      total_cnt_q <= '0;
    end else if (cmd_i.finish) begin
      out_prime_q <= prime_q;
      out_pal_q   <= pal_q;
      out_both_q  <= prime_q & pal_q;
      if (prime_q && prime_cnt_q != '1) prime_cnt_q <= prime_cnt_q + 1'b1;
      if (pal_q && pal_cnt_q != '1) pal_cnt_q <= pal_cnt_q + 1'b1;
      if (prime_q && pal_q && both_cnt_q != '1) both_cnt_q <= both_cnt_q + 1'b1;
      if (total_cnt_q != '1) total_cnt_q <= total_cnt_q + 1'b1;
    end
  end

  // status
  assign sts_o.neg      = n_q[W-1];
  assign sts_o.div_done = div_done;
  assign sts_o.quo_zero = (dig_quo_q == '0);
  assign sts_o.rem_zero = (div_rem == '0);
  assign sts_o.le_one   = (n_q <= W'(1));
  assign sts_o.sq_gt_n  = (sq_q > {1'b0, n_q});

  assign is_prime_o             = out_prime_q;
  assign is_palindrome_o        = out_pal_q;
  assign is_palindromic_prime_o = out_both_q;
  assign prime_count_o          = prime_cnt_q;
  assign palindrome_count_o     = pal_cnt_q;
  assign both_count_o           = both_cnt_q;
  assign total_count_o          = total_cnt_q;

  // counters move together, so the ordering between them always holds
  a_prime_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prime_cnt_q <= total_cnt_q)
    else $error("prime count above total count");

  a_both_le_prime: assert property (@(posedge clk_i) disable iff (!rst_ni)
    both_cnt_q <= prime_cnt_q && both_cnt_q <= pal_cnt_q)
    else $error("palindromic prime count above prime or palindrome count");

endmodule

`default_nettype wire

// File: rtl/ppc_ctrl.sv
// ----------------------------------------------------------------------------
// ppc_ctrl: classifier controller
// Sequences digit extraction, trial division and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppc_ctrl
  import ppc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  input  wire ppc_sts_t sts_i,
  output ppc_cmd_t      cmd_o
);

  ppc_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // state and result-valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_START;
        end
      end
      ST_START: begin
        // negatives are neither prime nor palindrome
        if (sts_i.neg) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.dig_div = 1'b1;
          state_d       = ST_PAL_STEP;
        end
      end
      ST_PAL_DIV: begin
        cmd_o.dig_div = 1'b1;
        state_d       = ST_PAL_STEP;
      end
      ST_PAL_STEP: begin
        cmd_o.pal_step = 1'b1;
        state_d        = sts_i.quo_zero ? ST_PAL_END : ST_PAL_DIV;
      end
      ST_PAL_END: begin
        cmd_o.pal_set = 1'b1;
        if (sts_i.le_one) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.prm_init = 1'b1;
          state_d        = ST_PRM_CHK;
        end
      end
      ST_PRM_CHK: begin
        if (sts_i.sq_gt_n) begin
          cmd_o.prm_set = 1'b1;
          state_d       = ST_FINISH;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_PRM_WAIT;
        end
      end
      ST_PRM_WAIT: begin
        if (sts_i.div_done) begin
          if (sts_i.rem_zero) begin
            state_d = ST_FINISH;
          end else begin
            cmd_o.prm_step = 1'b1;
            state_d        = ST_PRM_CHK;
          end
        end
      end
      ST_FINISH: begin
        // result slot free, or being emptied this cycle
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // result valid: set on finish, cleared once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> state_q == ST_PRM_WAIT)
    else $error("divider finished outside the trial wait state");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> state_q == ST_START)
    else $error("accepted request did not start classification");

  a_valid_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_FINISH)
    else $error("result raised outside finish");

endmodule

`default_nettype wire

// File: rtl/prime_palindrome_classifier_top.sv
// ----------------------------------------------------------------------------
// prime_palindrome_classifier_top: prime and palindrome classifier
// Classifies signed integers and keeps saturating running counts.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: number_i with in_valid_i / in_stall_o. A request is taken
//   on a rising edge with in_valid_i high and in_stall_o low. Only the low
//   NUMBER_WIDTH bits are used, bit NUMBER_WIDTH-1 being the sign.
//   Output channel: three flags and four counters with out_valid_o /
//   out_stall_i; one result per request, counts already include it.
//   One request is classified at a time. A negative number goes straight to
//   the hand-off. Otherwise each decimal digit takes a registered reciprocal
//   multiply by one tenth, then a fold; then each trial divisor d (2 up to
//   d*d > n) is tried in turn on the radix-2 divider.
//   A finished result sits in the output register while out_stall_i is
//   high; the next request is taken and worked on meanwhile, and waits for
//   the slot only at its own hand-off.
//   Reset empties the output, returns to idle and zeroes all counters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module prime_palindrome_classifier_top
  import ppc_pkg::*;
#(
  parameter int unsigned NUMBER_WIDTH = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [31:0] number_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    is_prime_o,
  output logic                    is_palindrome_o,
  output logic                    is_palindromic_prime_o,
  output logic [CntW-1:0]         prime_count_o,
  output logic [CntW-1:0]         palindrome_count_o,
  output logic [CntW-1:0]         both_count_o,
  output logic [CntW-1:0]         total_count_o
);

  ppc_cmd_t cmd;
  ppc_sts_t sts;

  ppc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ppc_dpath #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_dpath (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .number_i               (number_i[NUMBER_WIDTH-1:0]),
    .cmd_i                  (cmd),
    .sts_o                  (sts),
    .is_prime_o             (is_prime_o),
    .is_palindrome_o        (is_palindrome_o),
    .is_palindromic_prime_o (is_palindromic_prime_o),
    .prime_count_o          (prime_count_o),
    .palindrome_count_o     (palindrome_count_o),
    .both_count_o           (both_count_o),
    .total_count_o          (total_count_o)
  );

endmodule

`default_nettype wire
